@@ hdl/jls_pkg.sv @@
package jls_pkg;

  localparam int MaxUnknowns = 8;
  localparam int IdxW        = 3;
  localparam int FracBits    = 16;

  typedef enum logic [1:0] {
    CMD_LOAD_COEF  = 2'd0,
    CMD_LOAD_RHS   = 2'd1,
    CMD_LOAD_GUESS = 2'd2,
    CMD_START      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_ZERO_DIAG = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_MATRIX_SIZE = 2'd0,
    CFG_MAX_ITER    = 2'd1,
    CFG_TOLERANCE   = 2'd2
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DIAG_RD, S_DIAG_CHK, S_ROW_START, S_MAC_RD, S_MAC_MUL, S_MAC_ACC,
    S_DIV_START, S_DIV_WAIT, S_ERR_SQ, S_ERR_ACC, S_DECIDE, S_OUT_RD, S_OUT
  } state_e;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [65:0] num;   // signed numerator (already scaled)
    logic [31:0] den;   // signed divisor
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;  // saturated quotient
  } div_rsp_t;

endpackage

@@ hdl/jacobi_linear_solver_unit.sv @@
// Channel  | Direction | Payload
// s_axis   | in        | tdata = {value[31:0], col_index[2:0], row_index[2:0], cmd[1:0]}
// m_axis   | out       | tdata = {solution, unknown_index}, tuser = status, tlast = last
// cfg      | in        | cfg_we_i, cfg_index_i, cfg_data_i (no read-back)
//
// Loads are accepted only while idle. A start item first reads and checks each diagonal
// entry in turn, stopping at a zero, then runs sweeps: one shared 33x33 multiplier runs
// the dot product and the squared differences, and a shared radix-2 divider forms each x.
// The coefficient store is a 64-entry memory with a registered read port.
// Results leave through an output register, and the block waits on tready.
// Reset clears control only; the stores are undefined until written.
module jacobi_linear_solver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // cmd[1:0], row_index[4:2], col_index[7:5], value[39:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // unknown_index[2:0], solution[34:3], zeros
  output logic [1:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast,   // last
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam int IW = jls_pkg::IdxW;

  jls_pkg::state_e state_q, state_d;

  logic [3:0]  msize_q;
  logic [9:0]  maxit_q;
  logic [15:0] tol_q;

  logic signed [31:0] coef_mem [jls_pkg::MaxUnknowns * jls_pkg::MaxUnknowns];
  logic signed [31:0] rhs_q   [jls_pkg::MaxUnknowns];
  logic signed [31:0] cur_q   [jls_pkg::MaxUnknowns];
  logic signed [31:0] nxt_q   [jls_pkg::MaxUnknowns];

  logic [1:0]  in_cmd;
  logic [IW-1:0] in_row, in_col;
  logic [31:0] in_val;
  assign in_cmd = s_axis_tdata[1:0];
  assign in_row = s_axis_tdata[4:2];
  assign in_col = s_axis_tdata[7:5];
  assign in_val = s_axis_tdata[39:8];

  // sequencer registers
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic [9:0]    sweep_q, sweep_d;
  logic [1:0]    status_q, status_d;
  logic signed [65:0] sum_q, sum_d;
  logic [63:0]   err_q, err_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] coef_rd_q, diag_q, diag_d;
  logic [2*IW-1:0] rd_addr;
  logic          diff_sel_q, diff_sel_d;
  logic [3:0]    n_eff;
  logic [IW-1:0] n_last;
  logic          out_v_q, out_v_d, out_last_q;
  logic [IW-1:0] out_idx_q;
  logic [31:0]   out_sol_q;
  logic [1:0]    out_st_q;
  logic          out_load;

  jls_pkg::div_req_t div_req;
  jls_pkg::div_rsp_t div_rsp;

  jls_divider u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  assign n_eff  = (msize_q == 4'd0) ? 4'd1 :
                  (msize_q > 4'(jls_pkg::MaxUnknowns) ? 4'(jls_pkg::MaxUnknowns) : msize_q);
  assign n_last = IW'(n_eff - 4'd1);

  // shared multiplier operands: dot-product step or squared difference
  logic signed [32:0] diff;
  logic signed [32:0] mul_a, mul_b;
  logic [32:0]        dabs;
  assign diff = 33'(nxt_q[i_q]) - 33'(cur_q[i_q]);
  assign dabs = diff[32] ? 33'(-diff) : 33'(diff);

  always_comb begin
    if (diff_sel_q) begin
      mul_a = $signed(dabs);
      mul_b = $signed(dabs);
    end else begin
      mul_a = 33'(coef_rd_q);
      mul_b = 33'(cur_q[j_q]);
    end
  end
  logic signed [65:0] mul_full;
  assign mul_full = mul_a * mul_b;

  logic [63:0] err_sum;
  logic        err_cy;
  assign {err_cy, err_sum} = {1'b0, err_q} + {1'b0, prod_q};

  always_comb begin
    state_d = state_q; i_d = i_q; j_d = j_q; sweep_d = sweep_q;
    status_d = status_q; sum_d = sum_q; err_d = err_q; prod_d = prod_q;
    diag_d = diag_q; diff_sel_d = diff_sel_q; out_v_d = out_v_q; out_load = 1'b0;
    rd_addr = {i_q, j_q};
    div_req.start = 1'b0;
    div_req.num   = (66'(rhs_q[i_q]) - sum_q) <<< jls_pkg::FracBits;
    div_req.den   = diag_q;
    s_axis_tready = 1'b0;
    if (out_v_q && m_axis_tready) out_v_d = 1'b0;
    unique case (state_q)
      jls_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && in_cmd == jls_pkg::CMD_START) begin
          i_d = '0; sweep_d = '0; state_d = jls_pkg::S_DIAG_RD;
        end
      end
      jls_pkg::S_DIAG_RD: begin
        rd_addr = {i_q, i_q};
        state_d = jls_pkg::S_DIAG_CHK;
      end
      jls_pkg::S_DIAG_CHK: begin
        if (coef_rd_q == 32'sd0) begin
          status_d = jls_pkg::ST_ZERO_DIAG; i_d = '0; state_d = jls_pkg::S_OUT_RD;
        end else if (i_q == n_last) begin
          i_d = '0;
          if (maxit_q == 10'd0) begin
            status_d = jls_pkg::ST_LIMIT; state_d = jls_pkg::S_OUT_RD;
          end else begin
            state_d = jls_pkg::S_ROW_START;
          end
        end else begin
          i_d = i_q + 1'b1; state_d = jls_pkg::S_DIAG_RD;
        end
      end
      jls_pkg::S_ROW_START: begin
        sum_d = '0; j_d = '0; diff_sel_d = 1'b0;
        rd_addr = {i_q, i_q};
        state_d = jls_pkg::S_MAC_RD;
      end
      jls_pkg::S_MAC_RD: begin
        if (j_q == '0) diag_d = coef_rd_q;
        state_d = jls_pkg::S_MAC_MUL;
      end
      jls_pkg::S_MAC_MUL: begin
        prod_d = mul_full[63:0];
        state_d = jls_pkg::S_MAC_ACC;
      end
      jls_pkg::S_MAC_ACC: begin
        if (j_q != i_q) sum_d = sum_q + 66'(prod_q >>> jls_pkg::FracBits);
        if (j_q == n_last) begin
          state_d = jls_pkg::S_DIV_START;
        end else begin
          j_d = j_q + 1'b1;
          rd_addr = {i_q, IW'(j_q + 1'b1)};
          state_d = jls_pkg::S_MAC_RD;
        end
      end
      jls_pkg::S_DIV_START: begin
        div_req.start = 1'b1;
        state_d = jls_pkg::S_DIV_WAIT;
      end
      jls_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (i_q == n_last) begin
            i_d = '0; err_d = '0; diff_sel_d = 1'b1; state_d = jls_pkg::S_ERR_SQ;
          end else begin
            i_d = i_q + 1'b1; state_d = jls_pkg::S_ROW_START;
          end
        end
      end
      jls_pkg::S_ERR_SQ: begin
        prod_d = mul_full[63:0];
        state_d = jls_pkg::S_ERR_ACC;
      end
      jls_pkg::S_ERR_ACC: begin
        err_d = err_cy ? '1 : err_sum;
        if (i_q == n_last) begin
          sweep_d = sweep_q + 1'b1; state_d = jls_pkg::S_DECIDE;
        end else begin
          i_d = i_q + 1'b1; state_d = jls_pkg::S_ERR_SQ;
        end
      end
      jls_pkg::S_DECIDE: begin
        i_d = '0;
        if (err_q < 64'(tol_q) * 64'(tol_q)) begin
          status_d = jls_pkg::ST_CONVERGED; state_d = jls_pkg::S_OUT_RD;
        end else if (sweep_q >= maxit_q) begin
          status_d = jls_pkg::ST_LIMIT; state_d = jls_pkg::S_OUT_RD;
        end else begin
          state_d = jls_pkg::S_ROW_START;
        end
      end
      jls_pkg::S_OUT_RD: begin
        if (!out_v_q || m_axis_tready) begin
          out_load = 1'b1; out_v_d = 1'b1; state_d = jls_pkg::S_OUT;
        end
      end
      jls_pkg::S_OUT: begin
        if (i_q == n_last) begin
          state_d = jls_pkg::S_IDLE;
        end else begin
          i_d = i_q + 1'b1; state_d = jls_pkg::S_OUT_RD;
        end
      end
      default: state_d = jls_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jls_pkg::S_IDLE;
      msize_q <= 4'd8;
      maxit_q <= 10'd100;
      tol_q   <= 16'd1;
      out_v_q <= 1'b0;
      i_q <= '0; j_q <= '0; sweep_q <= '0; status_q <= '0;
      err_q <= '0; diff_sel_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      i_q <= i_d; j_q <= j_d; sweep_q <= sweep_d; status_q <= status_d;
      err_q <= err_d; diff_sel_q <= diff_sel_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          jls_pkg::CFG_MATRIX_SIZE: msize_q <= cfg_data_i[3:0];
          jls_pkg::CFG_MAX_ITER:    maxit_q <= cfg_data_i[9:0];
          jls_pkg::CFG_TOLERANCE:   tol_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // memory and payload registers
  always_ff @(posedge clk_i) begin
    coef_rd_q <= coef_mem[rd_addr];
    sum_q <= sum_d; prod_q <= prod_d; diag_q <= diag_d;
    if (s_axis_tvalid && s_axis_tready) begin
      unique case (in_cmd)
        jls_pkg::CMD_LOAD_COEF:  coef_mem[{in_row, in_col}] <= in_val;
        jls_pkg::CMD_LOAD_RHS:   rhs_q[in_row] <= in_val;
        jls_pkg::CMD_LOAD_GUESS: cur_q[in_row] <= in_val;
        default: ;
      endcase
    end
    if (state_q == jls_pkg::S_DIV_WAIT && div_rsp.done) nxt_q[i_q] <= div_rsp.quot;
    // commit the new iterate once its squared difference is taken
    if (state_q == jls_pkg::S_ERR_ACC) cur_q[i_q] <= nxt_q[i_q];
    if (out_load) begin
      out_idx_q  <= i_q;
      out_sol_q  <= cur_q[i_q];
      out_st_q   <= status_q;
      out_last_q <= (i_q == n_last);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0, out_sol_q, out_idx_q};
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_no_input_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != jls_pkg::S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jls_pkg::S_DECIDE) |-> (sweep_q <= maxit_q)) else $error("sweep overrun");
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3)) else $error("bad status");
`endif
endmodule

@@ hdl/jls_divider.sv @@
// Restoring divider, one quotient bit per cycle, saturating to 32-bit signed.
module jls_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jls_pkg::div_req_t req_i,
  output jls_pkg::div_rsp_t rsp_o
);
  localparam int NW = 66;

  logic [NW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic          neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [6:0]    cnt_q, cnt_d;
  logic [NW-1:0] num_abs, trial, qs;
  logic [NW:0]   rem_sh;
  logic [31:0]   sat;

  always_comb begin
    num_abs = req_i.num[NW-1] ? (~req_i.num + 1'b1) : req_i.num;
    rem_sh  = {rem_q, quo_q[NW-1]};
    trial   = rem_sh[NW-1:0] - dvs_q;
    qs      = neg_q ? (~quo_q + 1'b1) : quo_q;
    if (!neg_q && (quo_q > 66'h0_7FFF_FFFF)) begin
      sat = 32'h7FFF_FFFF;
    end else if (neg_q && (quo_q > 66'h0_8000_0000)) begin
      sat = 32'h8000_0000;
    end else begin
      sat = qs[31:0];
    end
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; neg_d = neg_q;
    busy_d = busy_q; cnt_d = cnt_q; done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = num_abs;
      dvs_d  = req_i.den[31] ? {34'd0, ~req_i.den + 1'b1} : {34'd0, req_i.den};
      neg_d  = req_i.num[NW-1] ^ req_i.den[31];
      busy_d = 1'b1;
      cnt_d  = 7'(NW);
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[NW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sat;
endmodule

@@ tb/tb_jacobi_linear_solver_unit.sv @@
module tb_jacobi_linear_solver_unit;

  // Run ceiling in clock cycles; far above the slowest legal schedule of this stimulus.
  localparam int unsigned CycleLimit = 20_000_000;
  // Cycles to hold off after the last result before touching the config port.
  localparam int          SettleCycles = 40;

  typedef struct {
    jls_pkg::cmd_e      cmd;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } request_t;

  typedef struct {
    logic [2:0]         idx;
    logic signed [31:0] sol;
    jls_pkg::status_e   status;
    logic               last;
  } solution_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // cmd, row_index, col_index, value (LSB first)
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // unknown_index, solution, zero fill (LSB first)
  logic [1:0]  m_axis_tuser;         // status
  logic        m_axis_tlast;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;

  jacobi_linear_solver_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus and scoreboard storage.
  request_t  pending_reqs[$];
  solution_t expected_sols[$];
  request_t  held_req;
  int        send_idle = 0;       // percent of cycles the sender holds off
  int        recv_idle = 0;       // percent of cycles the receiver stalls
  int        errors    = 0;
  int        n_checked = 0;
  int        n_starts  = 0;
  int        n_random  = 0;
  int unsigned cycles  = 0;

  // Shadow of the solver state, updated as requests are accepted.
  logic signed [31:0] sh_coef [8][8];
  logic signed [31:0] sh_rhs  [8];
  logic signed [31:0] sh_x    [8];
  logic [3:0]         sh_size = 4'd8;
  logic [9:0]         sh_iter = 10'd100;
  logic [15:0]        sh_tol  = 16'd1;

  // Generation-side view: which entries were written, and the active size.
  bit          coef_ok [8][8];
  bit          rhs_ok  [8];
  bit          x_ok    [8];
  logic [3:0]  gen_size = 4'd8;

  function automatic int clamp_n(logic [3:0] sz);
    if (sz == 0) return 1;
    if (sz > jls_pkg::MaxUnknowns) return jls_pkg::MaxUnknowns;
    return int'(sz);
  endfunction

  // Q16.16 quotient, truncating toward zero, saturated to 32 bits.
  function automatic logic signed [31:0] div_q16(longint num, longint den);
    longint q;
    longint lim;
    bit     neg;
    lim = longint'(1) << (62 - jls_pkg::FracBits);
    neg = (num < 0) != (den < 0);
    if (num >= lim || num <= -lim) return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    q = (num <<< jls_pkg::FracBits) / den;
    if (q > 64'sd2147483647)  return 32'sh7fff_ffff;
    if (q < -64'sd2147483648) return 32'sh8000_0000;
    return q[31:0];
  endfunction

  // Run the Jacobi sweeps on the shadow and queue the n results that follow.
  function automatic void solve_and_queue();
    int                 n;
    jls_pkg::status_e   st;
    int unsigned        sweeps;
    longint unsigned    tol_sq, err, sq, mag;
    longint             acc, diff;
    logic signed [31:0] xn [8];
    solution_t          r;
    n      = clamp_n(sh_size);
    tol_sq = longint'(sh_tol) * longint'(sh_tol);
    st     = jls_pkg::ST_LIMIT;
    sweeps = 0;
    for (int i = 0; i < n; i++)
      if (sh_coef[i][i] == 0) st = jls_pkg::ST_ZERO_DIAG;
    if (st != jls_pkg::ST_ZERO_DIAG) begin
      while (sweeps < sh_iter && st != jls_pkg::ST_CONVERGED) begin
        for (int i = 0; i < n; i++) begin
          acc = 0;
          for (int j = 0; j < n; j++)
            if (j != i)
              acc += (longint'(sh_coef[i][j]) * longint'(sh_x[j])) >>> jls_pkg::FracBits;
          xn[i] = div_q16(longint'(sh_rhs[i]) - acc, longint'(sh_coef[i][i]));
        end
        err = 0;
        for (int i = 0; i < n; i++) begin
          diff = longint'(xn[i]) - longint'(sh_x[i]);
          mag  = (diff < 0) ? -diff : diff;
          sq   = mag * mag;
          err  = (err > 64'hffff_ffff_ffff_ffff - sq) ? 64'hffff_ffff_ffff_ffff : err + sq;
          sh_x[i] = xn[i];
        end
        sweeps++;
        if (err < tol_sq) st = jls_pkg::ST_CONVERGED;
      end
    end
    for (int i = 0; i < n; i++) begin
      r.idx = i[2:0]; r.sol = sh_x[i]; r.status = st; r.last = (i == n - 1);
      expected_sols.push_back(r);
    end
  endfunction

  function automatic void apply_request(request_t q);
    case (q.cmd)
      jls_pkg::CMD_LOAD_COEF:  sh_coef[q.row][q.col] = q.value;
      jls_pkg::CMD_LOAD_RHS:   sh_rhs[q.row] = q.value;
      jls_pkg::CMD_LOAD_GUESS: sh_x[q.row] = q.value;
      default:                 solve_and_queue();
    endcase
  endfunction

  // Driver: present queued requests, holding each until it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) apply_request(held_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          held_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {held_req.value, held_req.col, held_req.row, held_req.cmd};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest prediction, stall at random.
  always @(posedge clk_i) begin
    solution_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sols.size() == 0) begin
          $display("%0t: unexpected result idx=%0d sol=%h", $time,
                   m_axis_tdata[2:0], m_axis_tdata[34:3]);
          errors++;
        end else begin
          e = expected_sols.pop_front();
          n_checked++;
          if (m_axis_tdata[2:0] !== e.idx) begin
            $display("%0t: unknown_index expected %0d actual %0d", $time, e.idx,
                     m_axis_tdata[2:0]);
            errors++;
          end
          if (m_axis_tdata[34:3] !== e.sol) begin
            $display("%0t: solution[%0d] expected %h actual %h", $time, e.idx, e.sol,
                     m_axis_tdata[34:3]);
            errors++;
          end
          if (m_axis_tdata[39:35] !== '0) begin
            $display("%0t: tdata fill expected 0 actual %h", $time, m_axis_tdata[39:35]);
            errors++;
          end
          if (m_axis_tuser !== e.status) begin
            $display("%0t: status[%0d] expected %0d actual %0d", $time, e.idx, e.status,
                     m_axis_tuser);
            errors++;
          end
          if (m_axis_tlast !== e.last) begin
            $display("%0t: last[%0d] expected %0d actual %0d", $time, e.idx, e.last,
                     m_axis_tlast);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout with %0d results outstanding", expected_sols.size());
      $display("FAIL");
      $finish;
    end
  end

  // Queue one load and note which store entry it fills.
  task automatic push_load(jls_pkg::cmd_e c, int r, int col, logic [31:0] v);
    request_t q;
    q.cmd = c; q.row = r[2:0]; q.col = col[2:0]; q.value = v;
    pending_reqs.push_back(q);
    n_random++;
    case (c)
      jls_pkg::CMD_LOAD_COEF:  coef_ok[r][col] = 1'b1;
      jls_pkg::CMD_LOAD_RHS:   rhs_ok[r] = 1'b1;
      default:                 x_ok[r] = 1'b1;
    endcase
  endtask

  // Fill any entry the solve would read but that was never written, then start.
  task automatic push_start();
    request_t q;
    int       n;
    n = clamp_n(gen_size);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++)
        if (!coef_ok[i][j])
          push_load(jls_pkg::CMD_LOAD_COEF, i, j, (i == j) ? 32'h0004_0000 : 32'h0);
      if (!rhs_ok[i]) push_load(jls_pkg::CMD_LOAD_RHS, i, 0, $urandom);
      if (!x_ok[i])   push_load(jls_pkg::CMD_LOAD_GUESS, i, 0, 32'h0);
    end
    q.cmd = jls_pkg::CMD_START; q.row = 3'($urandom); q.col = 3'($urandom);
    q.value = $urandom;
    pending_reqs.push_back(q);
    n_random++;
    n_starts++;
  endtask

  // Wait until every request is taken and every result is back, then settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_sols.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_cfg(jls_pkg::cfg_e idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      jls_pkg::CFG_MATRIX_SIZE: begin sh_size = data[3:0]; gen_size = data[3:0]; end
      jls_pkg::CFG_MAX_ITER:    sh_iter = data[9:0];
      default:                  sh_tol  = data;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Load a full system for the active size; mostly diagonally dominant.
  task automatic load_system(bit wild);
    int          n;
    logic [31:0] v;
    n = clamp_n(gen_size);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (wild) v = $urandom;
        else if (i == j) v = ($urandom_range(1) ? 32'd1 : -32'sd1) *
                             int'($urandom_range(32'h000f_ffff, 32'h0002_0000));
        else v = int'($urandom_range(65535)) - 32768;
        push_load(jls_pkg::CMD_LOAD_COEF, i, j, v);
      end
      push_load(jls_pkg::CMD_LOAD_RHS, i, 0,
                wild ? $urandom : int'($urandom_range(20 << 16)) - (10 << 16));
      push_load(jls_pkg::CMD_LOAD_GUESS, i, 0,
                wild ? $urandom : int'($urandom_range(8 << 16)) - (4 << 16));
    end
  endtask

  // Choose a register setting whose sweep count keeps the run short.
  task automatic random_config();
    int sz;
    case ($urandom_range(9))
      0:       sz = 0;
      1:       sz = $urandom_range(15, 9);
      2:       sz = $urandom_range(8, 5);
      default: sz = $urandom_range(4, 1);
    endcase
    write_cfg(jls_pkg::CFG_MATRIX_SIZE, 16'(sz));
    if (clamp_n(4'(sz)) == 1 && $urandom_range(5) == 0)
      write_cfg(jls_pkg::CFG_MAX_ITER, 16'd1023);
    else if ($urandom_range(11) == 0) write_cfg(jls_pkg::CFG_MAX_ITER, 16'd0);
    else write_cfg(jls_pkg::CFG_MAX_ITER,
                   16'($urandom_range(clamp_n(4'(sz)) > 4 ? 12 : 40, 1)));
    case ($urandom_range(5))
      0:       write_cfg(jls_pkg::CFG_TOLERANCE, 16'd0);
      1:       write_cfg(jls_pkg::CFG_TOLERANCE, 16'hffff);
      default: write_cfg(jls_pkg::CFG_TOLERANCE, 16'($urandom_range(16'h4000, 1)));
    endcase
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: saturating 2x2 with extreme values, loose tolerance.
    write_cfg(jls_pkg::CFG_MATRIX_SIZE, 16'd2);
    write_cfg(jls_pkg::CFG_MAX_ITER, 16'd4);
    write_cfg(jls_pkg::CFG_TOLERANCE, 16'hffff);
    push_load(jls_pkg::CMD_LOAD_COEF, 0, 0, 32'h7fff_ffff);
    push_load(jls_pkg::CMD_LOAD_COEF, 0, 1, 32'h8000_0000);
    push_load(jls_pkg::CMD_LOAD_COEF, 1, 0, 32'h0000_0001);
    push_load(jls_pkg::CMD_LOAD_COEF, 1, 1, 32'h8000_0000);
    push_load(jls_pkg::CMD_LOAD_RHS, 0, 7, 32'h7fff_ffff);
    push_load(jls_pkg::CMD_LOAD_RHS, 1, 7, 32'h8000_0000);
    push_load(jls_pkg::CMD_LOAD_GUESS, 0, 7, 32'h0);
    push_load(jls_pkg::CMD_LOAD_GUESS, 1, 7, 32'hffff_ffff);
    push_start();
    // Zero on the diagonal: no sweep, guesses returned unchanged.
    push_load(jls_pkg::CMD_LOAD_COEF, 1, 1, 32'h0);
    push_start();
    drain();
    // Iteration limit of zero: guesses come back with the limit status.
    push_load(jls_pkg::CMD_LOAD_COEF, 1, 1, 32'h0002_0000);
    write_cfg(jls_pkg::CFG_MAX_ITER, 16'd0);
    push_start();
    drain();
    // Size zero clamps to one unknown; zero tolerance runs the full 1023 sweeps.
    write_cfg(jls_pkg::CFG_MATRIX_SIZE, 16'd0);
    write_cfg(jls_pkg::CFG_MAX_ITER, 16'd1023);
    write_cfg(jls_pkg::CFG_TOLERANCE, 16'd0);
    push_start();
    drain();
    // Identity system settles on its second sweep, which is also the last allowed.
    write_cfg(jls_pkg::CFG_MATRIX_SIZE, 16'd2);
    write_cfg(jls_pkg::CFG_MAX_ITER, 16'd2);
    write_cfg(jls_pkg::CFG_TOLERANCE, 16'd1);
    push_load(jls_pkg::CMD_LOAD_COEF, 0, 0, 32'h0001_0000);
    push_load(jls_pkg::CMD_LOAD_COEF, 0, 1, 32'h0);
    push_load(jls_pkg::CMD_LOAD_COEF, 1, 0, 32'h0);
    push_load(jls_pkg::CMD_LOAD_COEF, 1, 1, 32'h0001_0000);
    push_load(jls_pkg::CMD_LOAD_GUESS, 0, 0, 32'h0);
    push_load(jls_pkg::CMD_LOAD_GUESS, 1, 0, 32'h0);
    push_start();
    drain();

    // Random: three handshake regimes, each a series of well-formed solves.
    n_random = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 21 : (ph == 1) ? 64 : 0;
      recv_idle = (ph == 0) ? 64 : (ph == 1) ? 21 : 0;
      target = 36 * (ph + 1);
      while (n_random < target) begin
        random_config();
        // Stray loads anywhere in the stores, ahead of the system proper.
        repeat ($urandom_range(3))
          push_load(jls_pkg::cmd_e'($urandom_range(2)), $urandom_range(7),
                    $urandom_range(7), $urandom);
        load_system($urandom_range(7) == 0);
        if ($urandom_range(7) == 0) begin
          int k;
          k = $urandom_range(clamp_n(gen_size) - 1);
          push_load(jls_pkg::CMD_LOAD_COEF, k, k, 32'h0);
        end
        push_start();
        drain();
      end
    end

    $display("covered %0d solve requests and %0d checked results, %0d mismatches",
             n_starts, n_checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
